>>> sv/rv32ie_pkg.sv
// ----------------------------------------------------------------------------
// rv32ie_pkg
// opcode, funct7 and funct3 codes and the stage record types of the execute unit
// ----------------------------------------------------------------------------
`default_nettype none

package rv32ie_pkg;

   // major opcodes
   localparam logic [6:0] OP_LUI    = 7'h37;
   localparam logic [6:0] OP_AUIPC  = 7'h17;
   localparam logic [6:0] OP_JAL    = 7'h6F;
   localparam logic [6:0] OP_JALR   = 7'h67;
   localparam logic [6:0] OP_BRANCH = 7'h63;
   localparam logic [6:0] OP_LOAD   = 7'h03;
   localparam logic [6:0] OP_STORE  = 7'h23;
   localparam logic [6:0] OP_IMM    = 7'h13;
   localparam logic [6:0] OP_REG    = 7'h33;

   // funct7 values
   localparam logic [6:0] F7_BASE = 7'h00;
   localparam logic [6:0] F7_ALT  = 7'h20;

   // alu funct3
   localparam logic [2:0] F3_ADD  = 3'd0;
   localparam logic [2:0] F3_SLL  = 3'd1;
   localparam logic [2:0] F3_SLT  = 3'd2;
   localparam logic [2:0] F3_SLTU = 3'd3;
   localparam logic [2:0] F3_XOR  = 3'd4;
   localparam logic [2:0] F3_SR   = 3'd5;
   localparam logic [2:0] F3_OR   = 3'd6;
   localparam logic [2:0] F3_AND  = 3'd7;

   // branch funct3
   localparam logic [2:0] F3_BEQ  = 3'd0;
   localparam logic [2:0] F3_BNE  = 3'd1;
   localparam logic [2:0] F3_BLT  = 3'd4;
   localparam logic [2:0] F3_BGE  = 3'd5;
   localparam logic [2:0] F3_BLTU = 3'd6;
   localparam logic [2:0] F3_BGEU = 3'd7;

   // load and store funct3
   localparam logic [2:0] F3_B  = 3'd0;
   localparam logic [2:0] F3_H  = 3'd1;
   localparam logic [2:0] F3_W  = 3'd2;
   localparam logic [2:0] F3_BU = 3'd4;
   localparam logic [2:0] F3_HU = 3'd5;

   // instruction between execute and writeback
   typedef struct packed {
      logic [31:0] next_pc;
      logic        wr;
      logic [4:0]  rd;
      logic [31:0] val;
      logic        is_load;
      logic [2:0]  f3;
      logic        st;
      logic [31:0] addr;
      logic        bad;
   } stage2_type;

   // result transaction
   typedef struct packed {
      logic [31:0] next_pc;
      logic        dest_write;
      logic [4:0]  dest_index;
      logic [31:0] dest_value;
      logic        store_done;
      logic [31:0] access_address;
      logic        illegal;
   } result_type;

endpackage

`default_nettype wire

>>> sv/rv32ie_if.sv
// ----------------------------------------------------------------------------
// rv32ie channel interfaces
// valid/ready channels for instructions, results and the start pc write
// ----------------------------------------------------------------------------
`default_nettype none

interface rv32ie_req_if;
   logic        valid;
   logic        ready;
   logic [31:0] instruction_word;
   modport source (output valid, output instruction_word, input ready);
   modport sink (input valid, input instruction_word, output ready);
endinterface

interface rv32ie_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] next_pc;
   logic        dest_write;
   logic [4:0]  dest_index;
   logic [31:0] dest_value;
   logic        store_done;
   logic [31:0] access_address;
   logic        illegal;
   modport source (output valid, output next_pc, output dest_write, output dest_index,
                   output dest_value, output store_done, output access_address,
                   output illegal, input ready);
   modport sink (input valid, input next_pc, input dest_write, input dest_index,
                 input dest_value, input store_done, input access_address,
                 input illegal, output ready);
endinterface

interface rv32ie_csr_if;
   logic        valid;
   logic        ready;
   logic [31:0] start_pc;
   modport source (output valid, output start_pc, input ready);
   modport sink (input valid, input start_pc, output ready);
endinterface

`default_nettype wire

>>> sv/rv32i_instruction_execute.sv
// a result is registered in stage 1, stage 2 and the output register before it is offered
// throughput: one instruction per cycle while the result side keeps up
// the register file read at accept and the data memory read in execute set the depth
// reset: pc goes to 0, registers read as zero, then the data memory is cleared
// one word a cycle until all DATA_WORDS words are zero, during which no instruction is taken
// ----------------------------------------------------------------------------
// rv32i_instruction_execute
// RV32I execute unit: register file and data memory in synchronous rams,
// read at accept, execute with forwarding, load data and writeback
// ----------------------------------------------------------------------------
`default_nettype none

module rv32i_instruction_execute #(
   parameter int DATA_WORDS = 4096
) (
   input  wire              clock,
   input  wire              reset,
   rv32ie_req_if.sink       req_chan,
   rv32ie_rsp_if.source     rsp_chan,
   rv32ie_csr_if.sink       csr_chan
);

   localparam int AW = $clog2(DATA_WORDS);

   // storage
   logic [31:0] rf_mem [32];
   logic [31:0] dmem [DATA_WORDS];

   // control
   logic        s1_valid_ff, s1_valid_in;
   logic        s2_valid_ff, s2_valid_in;
   logic        out_valid_ff, out_valid_in;
   logic [31:0] s1_instr_ff;
   logic [31:0] pc_ff;
   logic [31:0] rf_valid_ff;
   logic        clr_busy_ff;
   logic [AW-1:0] clr_idx_ff;

   rv32ie_pkg::stage2_type s2_ff, s2_in;
   rv32ie_pkg::result_type out_ff;

   logic accept, s1_go, s2_go;

   // register read data with bypass of commits made after the read
   logic [31:0] rf_q1_ff, rf_q2_ff;
   logic        rs1_ok_ff, rs2_ok_ff;
   logic        rs1_byp_ff, rs2_byp_ff;
   logic [31:0] rs1_bval_ff, rs2_bval_ff;

   logic        wb_en;
   logic [4:0]  wb_rd;
   logic [31:0] wb_val;

   logic [31:0] mem_q_ff;

   logic [4:0] req_rs1, req_rs2, s1_rs1, s1_rs2;

   // handshake
   assign s2_go       = s2_valid_ff && (!out_valid_ff || rsp_chan.ready);
   assign s1_go       = s1_valid_ff && (!s2_valid_ff || s2_go);
   assign req_chan.ready = !clr_busy_ff && (!s1_valid_ff || s1_go);
   assign accept      = req_chan.valid && req_chan.ready;
   assign csr_chan.ready = 1'b1;

   assign req_rs1 = req_chan.instruction_word[19:15];
   assign req_rs2 = req_chan.instruction_word[24:20];
   assign s1_rs1  = s1_instr_ff[19:15];
   assign s1_rs2  = s1_instr_ff[24:20];

   // final writeback value of stage 2, loads formatted from memory data
   logic [31:0] s2_value;
   always_comb begin
      logic [4:0]  sh;
      logic [31:0] x;
      sh = 5'd0;
      x  = 32'd0;
      s2_value = s2_ff.val;
      if (s2_ff.is_load) begin
         if (s2_ff.f3 == rv32ie_pkg::F3_H || s2_ff.f3 == rv32ie_pkg::F3_HU) begin
            sh = {s2_ff.addr[1], 4'd0};
         end else begin
            sh = {s2_ff.addr[1:0], 3'd0};
         end
         x = mem_q_ff >> sh;
         unique case (s2_ff.f3)
            rv32ie_pkg::F3_B:  s2_value = {{24{x[7]}}, x[7:0]};
            rv32ie_pkg::F3_H:  s2_value = {{16{x[15]}}, x[15:0]};
            rv32ie_pkg::F3_BU: s2_value = {24'd0, x[7:0]};
            rv32ie_pkg::F3_HU: s2_value = {16'd0, x[15:0]};
            default:           s2_value = mem_q_ff;
         endcase
      end
   end

   assign wb_en  = s2_go && s2_ff.wr;
   assign wb_rd  = s2_ff.rd;
   assign wb_val = s2_value;

   // operands with forwarding from the instruction in stage 2
   logic [31:0] op_a, op_b;
   always_comb begin
      if (s2_valid_ff && s2_ff.wr && s2_ff.rd == s1_rs1) begin
         op_a = s2_value;
      end else if (rs1_byp_ff) begin
         op_a = rs1_bval_ff;
      end else begin
         op_a = rs1_ok_ff ? rf_q1_ff : 32'd0;
      end
      if (s2_valid_ff && s2_ff.wr && s2_ff.rd == s1_rs2) begin
         op_b = s2_value;
      end else if (rs2_byp_ff) begin
         op_b = rs2_bval_ff;
      end else begin
         op_b = rs2_ok_ff ? rf_q2_ff : 32'd0;
      end
   end

   // execute: decode, alu, branch, address and store lanes
   logic [3:0]  st_be;
   logic [31:0] st_data;
   always_comb begin
      logic [31:0] w, immi, imms, immb, immj, alu_b, res, npc, val, addr;
      logic [6:0]  op, f7;
      logic [2:0]  f3;
      logic [4:0]  rd;
      logic        wr, st, bad, take, ld, is_reg, alt;
      w    = s1_instr_ff;
      op   = w[6:0];
      rd   = w[11:7];
      f3   = w[14:12];
      f7   = w[31:25];
      immi = {{20{w[31]}}, w[31:20]};
      imms = {{20{w[31]}}, w[31:25], w[11:7]};
      immb = {{19{w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};
      immj = {{11{w[31]}}, w[31], w[19:12], w[20], w[30:21], 1'b0};
      npc  = pc_ff + 32'd4;
      wr   = 1'b0;
      st   = 1'b0;
      bad  = 1'b0;
      ld   = 1'b0;
      take = 1'b0;
      val  = 32'd0;
      addr = 32'd0;
      st_be   = 4'd0;
      st_data = 32'd0;
      is_reg  = (op == rv32ie_pkg::OP_REG);
      alt     = is_reg ? (f7 == rv32ie_pkg::F7_ALT)
                       : (f3 == rv32ie_pkg::F3_SR && f7 == rv32ie_pkg::F7_ALT);
      alu_b   = is_reg ? op_b : immi;

      // shared alu
      unique case (f3)
         rv32ie_pkg::F3_ADD:  res = (is_reg && alt) ? op_a - alu_b : op_a + alu_b;
         rv32ie_pkg::F3_SLL:  res = op_a << alu_b[4:0];
         rv32ie_pkg::F3_SLT:  res = {31'd0, $signed(op_a) < $signed(alu_b)};
         rv32ie_pkg::F3_SLTU: res = {31'd0, op_a < alu_b};
         rv32ie_pkg::F3_XOR:  res = op_a ^ alu_b;
         rv32ie_pkg::F3_SR:   res = alt ? $unsigned($signed(op_a) >>> alu_b[4:0])
                                        : op_a >> alu_b[4:0];
         rv32ie_pkg::F3_OR:   res = op_a | alu_b;
         default:             res = op_a & alu_b;
      endcase

      unique case (op)
         rv32ie_pkg::OP_LUI: begin
            wr  = 1'b1;
            val = {w[31:12], 12'd0};
         end
         rv32ie_pkg::OP_AUIPC: begin
            wr  = 1'b1;
            val = pc_ff + {w[31:12], 12'd0};
         end
         rv32ie_pkg::OP_JAL: begin
            wr  = 1'b1;
            val = pc_ff + 32'd4;
            npc = pc_ff + immj;
         end
         rv32ie_pkg::OP_JALR: begin
            if (f3 != 3'd0) begin
               bad = 1'b1;
            end else begin
               wr  = 1'b1;
               val = pc_ff + 32'd4;
               npc = (op_a + immi) & ~32'd1;
            end
         end
         rv32ie_pkg::OP_BRANCH: begin
            unique case (f3)
               rv32ie_pkg::F3_BEQ:  take = (op_a == op_b);
               rv32ie_pkg::F3_BNE:  take = (op_a != op_b);
               rv32ie_pkg::F3_BLT:  take = $signed(op_a) < $signed(op_b);
               rv32ie_pkg::F3_BGE:  take = !($signed(op_a) < $signed(op_b));
               rv32ie_pkg::F3_BLTU: take = (op_a < op_b);
               rv32ie_pkg::F3_BGEU: take = (op_a >= op_b);
               default:             bad = 1'b1;
            endcase
            if (take) begin
               npc = pc_ff + immb;
            end
         end
         rv32ie_pkg::OP_LOAD: begin
            addr = op_a + immi;
            if (f3 == rv32ie_pkg::F3_B || f3 == rv32ie_pkg::F3_H || f3 == rv32ie_pkg::F3_W
                || f3 == rv32ie_pkg::F3_BU || f3 == rv32ie_pkg::F3_HU) begin
               wr = 1'b1;
               ld = 1'b1;
            end else begin
               bad = 1'b1;
            end
         end
         rv32ie_pkg::OP_STORE: begin
            addr = op_a + imms;
            unique case (f3)
               rv32ie_pkg::F3_B: begin
                  st      = 1'b1;
                  st_be   = 4'b0001 << addr[1:0];
                  st_data = op_b << {addr[1:0], 3'd0};
               end
               rv32ie_pkg::F3_H: begin
                  st      = 1'b1;
                  st_be   = 4'b0011 << {addr[1], 1'b0};
                  st_data = op_b << {addr[1], 4'd0};
               end
               rv32ie_pkg::F3_W: begin
                  st      = 1'b1;
                  st_be   = 4'b1111;
                  st_data = op_b;
               end
               default: bad = 1'b1;
            endcase
         end
         rv32ie_pkg::OP_IMM: begin
            if ((f3 == rv32ie_pkg::F3_SLL && f7 != rv32ie_pkg::F7_BASE)
                || (f3 == rv32ie_pkg::F3_SR && f7 != rv32ie_pkg::F7_BASE
                    && f7 != rv32ie_pkg::F7_ALT)) begin
               bad = 1'b1;
            end else begin
               wr  = 1'b1;
               val = res;
            end
         end
         rv32ie_pkg::OP_REG: begin
            if ((f7 == rv32ie_pkg::F7_ALT && f3 != rv32ie_pkg::F3_ADD
                 && f3 != rv32ie_pkg::F3_SR)
                || (f7 != rv32ie_pkg::F7_BASE && f7 != rv32ie_pkg::F7_ALT)) begin
               bad = 1'b1;
            end else begin
               wr  = 1'b1;
               val = res;
            end
         end
         default: bad = 1'b1;
      endcase

      // illegal and x0 cleanup
      if (bad) begin
         wr    = 1'b0;
         st    = 1'b0;
         ld    = 1'b0;
         val   = 32'd0;
         addr  = 32'd0;
         npc   = pc_ff + 32'd4;
         st_be = 4'd0;
      end
      if (!wr || rd == 5'd0) begin
         wr  = 1'b0;
         rd  = 5'd0;
         val = 32'd0;
      end

      s2_in.next_pc = npc;
      s2_in.wr      = wr;
      s2_in.rd      = rd;
      s2_in.val     = val;
      s2_in.is_load = ld && wr;
      s2_in.f3      = f3;
      s2_in.st      = st;
      s2_in.addr    = addr;
      s2_in.bad     = bad;
   end

   // pipeline valids
   always_comb begin
      s1_valid_in  = accept ? 1'b1 : (s1_go ? 1'b0 : s1_valid_ff);
      s2_valid_in  = s1_go ? 1'b1 : (s2_go ? 1'b0 : s2_valid_ff);
      out_valid_in = s2_go ? 1'b1 : (rsp_chan.ready ? 1'b0 : out_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         pc_ff        <= 32'd0;
         rf_valid_ff  <= 32'd0;
         clr_busy_ff  <= 1'b1;
         clr_idx_ff   <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         out_valid_ff <= out_valid_in;
         if (csr_chan.valid) begin
            pc_ff <= csr_chan.start_pc;
         end else if (s1_go) begin
            pc_ff <= s2_in.next_pc;
         end
         if (wb_en) begin
            rf_valid_ff[wb_rd] <= 1'b1;
         end
         if (clr_busy_ff) begin
            clr_idx_ff <= clr_idx_ff + 1'b1;
            if (clr_idx_ff == AW'(DATA_WORDS - 1)) begin
               clr_busy_ff <= 1'b0;
            end
         end
      end
   end

   // stage payloads
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_instr_ff <= req_chan.instruction_word;
      end
      if (s1_go) begin
         s2_ff <= s2_in;
      end
      if (s2_go) begin
         out_ff.next_pc        <= s2_ff.next_pc;
         out_ff.dest_write     <= s2_ff.wr;
         out_ff.dest_index     <= s2_ff.rd;
         out_ff.dest_value     <= s2_value;
         out_ff.store_done     <= s2_ff.st;
         out_ff.access_address <= s2_ff.addr;
         out_ff.illegal        <= s2_ff.bad;
      end
   end

   // register file ram, two read ports at accept, write at commit
   always_ff @(posedge clock) begin
      if (accept) begin
         rf_q1_ff <= rf_mem[req_rs1];
         rf_q2_ff <= rf_mem[req_rs2];
      end
      if (wb_en) begin
         rf_mem[wb_rd] <= wb_val;
      end
   end

   // read bypass: same-edge commits and commits while the instruction waits
   always_ff @(posedge clock) begin
      if (reset) begin
         rs1_byp_ff <= 1'b0;
         rs2_byp_ff <= 1'b0;
         rs1_ok_ff  <= 1'b0;
         rs2_ok_ff  <= 1'b0;
      end else if (accept) begin
         rs1_ok_ff  <= rf_valid_ff[req_rs1];
         rs2_ok_ff  <= rf_valid_ff[req_rs2];
         rs1_byp_ff <= wb_en && wb_rd == req_rs1;
         rs2_byp_ff <= wb_en && wb_rd == req_rs2;
      end else if (wb_en && s1_valid_ff) begin
         if (wb_rd == s1_rs1) begin
            rs1_byp_ff <= 1'b1;
         end
         if (wb_rd == s1_rs2) begin
            rs2_byp_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (wb_en && (accept ? wb_rd == req_rs1 : wb_rd == s1_rs1)) begin
         rs1_bval_ff <= wb_val;
      end
      if (wb_en && (accept ? wb_rd == req_rs2 : wb_rd == s1_rs2)) begin
         rs2_bval_ff <= wb_val;
      end
   end

   // data memory ram: clearing pass or store write, load read in execute
   logic [AW-1:0] d_idx;
   assign d_idx = s2_in.addr[AW+1:2];

   always_ff @(posedge clock) begin
      if (clr_busy_ff) begin
         dmem[clr_idx_ff] <= 32'd0;
      end else if (s1_go && s2_in.st) begin
         for (int i = 0; i < 4; i++) begin
            if (st_be[i]) begin
               dmem[d_idx][8*i +: 8] <= st_data[8*i +: 8];
            end
         end
      end
      if (s1_go && s2_in.is_load) begin
         mem_q_ff <= dmem[d_idx];
      end
   end

   // result channel
   assign rsp_chan.valid          = out_valid_ff;
   assign rsp_chan.next_pc        = out_ff.next_pc;
   assign rsp_chan.dest_write     = out_ff.dest_write;
   assign rsp_chan.dest_index     = out_ff.dest_index;
   assign rsp_chan.dest_value     = out_ff.dest_value;
   assign rsp_chan.store_done     = out_ff.store_done;
   assign rsp_chan.access_address = out_ff.access_address;
   assign rsp_chan.illegal        = out_ff.illegal;

`ifndef ASSERT_OFF
   // no instruction enters while the memory is being cleared
   a_no_accept_clear: assert property (@(posedge clock) disable iff (reset)
      clr_busy_ff |-> !accept) else $error("instruction taken during clear");

   // illegal instructions change nothing
   a_illegal_quiet: assert property (@(posedge clock) disable iff (reset)
      (s2_valid_ff && s2_ff.bad) |-> (!s2_ff.wr && !s2_ff.st && s2_ff.addr == 32'd0))
      else $error("illegal instruction with side effect");

   // x0 is never written
   a_no_x0_write: assert property (@(posedge clock) disable iff (reset)
      wb_en |-> wb_rd != 5'd0) else $error("write to x0");

   // a stalled writeback stage keeps its instruction
   a_s2_hold: assert property (@(posedge clock) disable iff (reset)
      (s2_valid_ff && !s2_go) |=> (s2_valid_ff && $stable(s2_ff)))
      else $error("stage 2 lost while stalled");
`endif

endmodule

`default_nettype wire
